>>> rtl/dlbr_pkg.sv
// Package for the dense layer block: sizes, op and register codes,
// controller/datapath interface structs. No dependencies.
package dlbr_pkg;

  localparam int MAX_IN_FEATURES  = 64;
  localparam int MAX_OUT_FEATURES = 16;

  localparam int VAL_W     = 16;
  localparam int PROD_W    = 2 * VAL_W;
  localparam int ACC_W     = 40;
  localparam int SUM_W     = ACC_W + 1;
  localparam int FI_W      = 6;
  localparam int OI_W      = 4;
  localparam int IN_CNT_W  = 7;
  localparam int OUT_CNT_W = 5;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;
  localparam int WADDR_W   = FI_W + OI_W;
  localparam int W_DEPTH   = MAX_IN_FEATURES * MAX_OUT_FEATURES;

  // request op codes
  localparam logic [OP_W-1:0] OP_WEIGHT  = 2'd0;
  localparam logic [OP_W-1:0] OP_BIAS    = 2'd1;
  localparam logic [OP_W-1:0] OP_FEATURE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU      = 2'd2;

  localparam logic [IN_CNT_W-1:0]  IN_COUNT_RST  = 7'd64;
  localparam logic [OUT_CNT_W-1:0] OUT_COUNT_RST = 5'd16;

  typedef struct packed {
    logic            wr_weight;
    logic            wr_bias;
    logic            load_feat;
    logic            rd_en;
    logic [OI_W-1:0] k;
    logic            out_load;
    logic            out_last;
  } dlbr_cmd_t;

  typedef struct packed {
    logic            is_weight;
    logic            is_bias;
    logic            is_feat;
    logic            feat_last;
    logic [OI_W-1:0] nout_m1;
    logic            pipe_idle;
  } dlbr_sts_t;

endpackage

>>> rtl/dlbr_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dlbr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> rtl/dlbr_ctrl.sv
// Controller for the dense layer: request accept, MAC issue sequencing and
// result emission. Depends on dlbr_pkg.
module dlbr_ctrl import dlbr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  dlbr_sts_t sts,
  output dlbr_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_MAC, S_OUT} state_t;

  state_t          state_r, state_nxt;
  logic [OI_W-1:0] k_r, k_nxt;
  logic            issue_done_r, issue_done_nxt;
  logic            last_r, last_nxt;
  logic            out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    issue_done_nxt = issue_done_r;
    last_nxt       = last_r;
    cmd            = '0;
    cmd.k          = k_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_weight = sts.is_weight;
          cmd.wr_bias   = sts.is_bias;
          if (sts.is_feat) begin
            cmd.load_feat  = 1'b1;
            state_nxt      = S_MAC;
            k_nxt          = '0;
            issue_done_nxt = 1'b0;
            last_nxt       = sts.feat_last;
          end
        end
      end
      S_MAC: begin
        if (!issue_done_r) begin
          cmd.rd_en = 1'b1;
          if (k_r == sts.nout_m1) begin
            issue_done_nxt = 1'b1;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else if (sts.pipe_idle) begin
          k_nxt     = '0;
          state_nxt = last_r ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        // output register frees up when empty or being taken this cycle
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (k_r == sts.nout_m1);
          if (k_r == sts.nout_m1) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      k_r          <= '0;
      issue_done_r <= 1'b0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      k_r          <= k_nxt;
      issue_done_r <= issue_done_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/dlbr_dp.sv
// Datapath for the dense layer: config registers, weight RAM, bias registers,
// MAC pipeline, accumulators and output stage. Depends on dlbr_pkg, dlbr_ram.
module dlbr_dp import dlbr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  input  logic [OP_W-1:0]         in_op,
  input  logic [FI_W-1:0]         in_feature_index,
  input  logic [OI_W-1:0]         in_output_index,
  input  logic signed [VAL_W-1:0] in_value,
  input  dlbr_cmd_t               cmd,
  output dlbr_sts_t               sts,
  output logic [OI_W-1:0]         out_feature,
  output logic signed [VAL_W-1:0] out_result,
  output logic                    out_row_done
);

  localparam logic signed [SUM_W-9:0] Q_MAX = 33'sd32767;
  localparam logic signed [SUM_W-9:0] Q_MIN = -33'sd32768;

  logic [IN_CNT_W-1:0]      in_count_r;
  logic [OUT_CNT_W-1:0]     out_count_r;
  logic                     relu_r;
  logic [IN_CNT_W-1:0]      nin;
  logic [OI_W-1:0]          nout_m1;
  logic [FI_W-1:0]          fi_r;
  logic signed [VAL_W-1:0]  val_r;
  logic [VAL_W-1:0]         w_rdata;
  logic                     rd_v_r;
  logic [OI_W-1:0]          rd_k_r;
  logic                     mul_v_r;
  logic [OI_W-1:0]          mul_k_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r  [MAX_OUT_FEATURES];
  logic [VAL_W-1:0]         bias_r [MAX_OUT_FEATURES];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_relu;
  logic signed [SUM_W-9:0]  q;
  logic [VAL_W-1:0]         q_sat;
  logic [OI_W-1:0]          out_feature_r;
  logic [VAL_W-1:0]         result_r;
  logic                     row_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= IN_COUNT_RST;
      out_count_r <= OUT_COUNT_RST;
      relu_r      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_COUNT:  in_count_r  <= cfg_data[IN_CNT_W-1:0];
        CFG_OUT_COUNT: out_count_r <= cfg_data[OUT_CNT_W-1:0];
        CFG_RELU:      relu_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // out-of-range counts fold into 1..max
  always_comb begin
    if (in_count_r == '0) begin
      nin = IN_CNT_W'(1);
    end else if (in_count_r > IN_CNT_W'(MAX_IN_FEATURES)) begin
      nin = IN_CNT_W'(MAX_IN_FEATURES);
    end else begin
      nin = in_count_r;
    end
    if (out_count_r == '0) begin
      nout_m1 = '0;
    end else if (out_count_r > OUT_CNT_W'(MAX_OUT_FEATURES)) begin
      nout_m1 = OI_W'(MAX_OUT_FEATURES - 1);
    end else begin
      nout_m1 = OI_W'(out_count_r - 1'b1);
    end
  end

  assign sts.nout_m1   = nout_m1;
  assign sts.is_weight = (in_op == OP_WEIGHT);
  assign sts.is_bias   = (in_op == OP_BIAS);
  assign sts.is_feat   = (in_op == OP_FEATURE) && ({1'b0, in_feature_index} < nin);
  assign sts.feat_last = ({1'b0, in_feature_index} == (nin - 1'b1));
  assign sts.pipe_idle = !rd_v_r && !mul_v_r;

  dlbr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (cmd.wr_weight),
    .waddr ({in_feature_index, in_output_index}),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr ({fi_r, cmd.k}),
    .rdata (w_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.wr_bias) begin
      bias_r[in_output_index] <= in_value;
    end
    if (cmd.load_feat) begin
      fi_r  <= in_feature_index;
      val_r <= in_value;
    end
    rd_k_r  <= cmd.k;
    mul_k_r <= rd_k_r;
    prod_r  <= val_r * $signed(w_rdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      rd_v_r  <= cmd.rd_en;
      mul_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_OUT_FEATURES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.load_feat && (in_feature_index == '0)) begin
      for (int i = 0; i < MAX_OUT_FEATURES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (mul_v_r) begin
      acc_r[mul_k_r] <= acc_r[mul_k_r] + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // acc + bias*256, optional ReLU, floor shift by 8, saturate
  always_comb begin
    sum = $signed({acc_r[cmd.k][ACC_W-1], acc_r[cmd.k]})
        + $signed({{(SUM_W-VAL_W-8){bias_r[cmd.k][VAL_W-1]}}, bias_r[cmd.k], 8'b0});
    sum_relu = (relu_r && sum[SUM_W-1]) ? '0 : sum;
    q = sum_relu[SUM_W-1:8];
    if (q > Q_MAX) begin
      q_sat = Q_MAX[VAL_W-1:0];
    end else if (q < Q_MIN) begin
      q_sat = Q_MIN[VAL_W-1:0];
    end else begin
      q_sat = q[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_feature_r <= cmd.k;
      result_r      <= q_sat;
      row_done_r    <= cmd.out_last;
    end
  end

  assign out_feature  = out_feature_r;
  assign out_result   = result_r;
  assign out_row_done = row_done_r;

endmodule

>>> rtl/dense_layer_bias_relu.sv
// Top level of the fully connected layer with bias and ReLU.
// Depends on dlbr_pkg, dlbr_ctrl, dlbr_dp (which holds dlbr_ram).
//
//   channel  ports                                   direction
//   in       in_valid/in_ready, op, indices, value   weight, bias or feature request
//   out      out_valid/out_ready, feature, result    one result per used output
//   cfg      cfg_we, cfg_index, cfg_data             in_count, out_count, relu_enable
//
// Weight and bias writes do not hold in_ready low. A feature holds it low after
// it is taken, while weight RAM reads for the used outputs issue and drain
// (weight RAM read, product register and accumulator update on one shared
// multiplier); the next feature waits for that. The row's last feature then
// emits a result per used output, one per cycle while out_ready is high, with in_ready
// still low. Reset is synchronous; accumulators clear, the weight RAM is not
// cleared. A stalled output holds its register and the input waits; once the
// row's last result sits in that register the next request is taken.
module dense_layer_bias_relu import dlbr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_op,
  input  logic [FI_W-1:0]         in_feature_index,
  input  logic [OI_W-1:0]         in_output_index,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [OI_W-1:0]         out_feature,
  output logic signed [VAL_W-1:0] out_result,
  output logic                    out_row_done
);

  dlbr_cmd_t cmd;
  dlbr_sts_t sts;

  dlbr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dlbr_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_op            (in_op),
    .in_feature_index (in_feature_index),
    .in_output_index  (in_output_index),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_feature      (out_feature),
    .out_result       (out_result),
    .out_row_done     (out_row_done)
  );

endmodule

>>> tb/sv/dlbr_tb_pkg.sv
// Testbench package for the dense layer: the expected-output record and a
// tracker class that predicts each row's outputs and checks the block's results.
// Depends on dlbr_pkg.
package dlbr_tb_pkg;
  import dlbr_pkg::*;

  typedef struct packed {
    logic [OI_W-1:0]  feature;
    logic [VAL_W-1:0] result;
    logic             row_done;
  } layer_output_t;

  class dense_layer_tracker;
    logic signed [VAL_W-1:0] weights [W_DEPTH];
    logic signed [VAL_W-1:0] biases  [MAX_OUT_FEATURES];
    logic signed [ACC_W-1:0] acc     [MAX_OUT_FEATURES];
    logic [IN_CNT_W-1:0]     in_count;
    logic [OUT_CNT_W-1:0]    out_count;
    logic                    relu_on;
    layer_output_t           expected_outputs [$];
    int                      errors;

    function new();
      foreach (weights[i]) weights[i] = '0;
      foreach (biases[i]) biases[i] = '0;
      foreach (acc[i]) acc[i] = '0;
      in_count  = IN_COUNT_RST;
      out_count = OUT_COUNT_RST;
      relu_on   = 1'b0;
      errors    = 0;
    endfunction

    // register values outside the legal range are clamped
    function int used_in();
      if (in_count == 0) return 1;
      if (in_count > MAX_IN_FEATURES) return MAX_IN_FEATURES;
      return in_count;
    endfunction

    function int used_out();
      if (out_count == 0) return 1;
      if (out_count > MAX_OUT_FEATURES) return MAX_OUT_FEATURES;
      return out_count;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        CFG_IN_COUNT:  in_count  = data[IN_CNT_W-1:0];
        CFG_OUT_COUNT: out_count = data[OUT_CNT_W-1:0];
        CFG_RELU:      relu_on   = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [FI_W-1:0] fi,
                               logic [OI_W-1:0] oi, logic signed [VAL_W-1:0] val);
      int                       nin;
      int                       nout;
      logic signed [PROD_W-1:0] prod;
      logic signed [SUM_W-1:0]  sum;
      logic signed [SUM_W-1:0]  bias_term;
      logic signed [SUM_W-1:0]  scaled;
      layer_output_t            item;
      nin  = used_in();
      nout = used_out();
      case (op)
        OP_WEIGHT: weights[fi * MAX_OUT_FEATURES + oi] = val;
        OP_BIAS:   biases[oi] = val;
        OP_FEATURE: if (fi < nin) begin
          if (fi == 0) foreach (acc[k]) acc[k] = '0;
          for (int k = 0; k < nout; k++) begin
            prod   = val * weights[fi * MAX_OUT_FEATURES + k];
            acc[k] = acc[k] + prod;
          end
          if (fi == nin - 1) begin
            for (int k = 0; k < nout; k++) begin
              sum       = acc[k];
              bias_term = biases[k];
              sum       = sum + (bias_term <<< 8);
              if (relu_on && sum < 0) sum = '0;
              // floor divide by 256, then saturate to Q8.8
              scaled = sum >>> 8;
              if (scaled > 32767) scaled = 32767;
              else if (scaled < -32768) scaled = -32768;
              item.feature  = OI_W'(k);
              item.result   = scaled[VAL_W-1:0];
              item.row_done = (k == nout - 1);
              expected_outputs.push_back(item);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_output(logic [OI_W-1:0] feat, logic [VAL_W-1:0] res, logic done);
      layer_output_t want;
      if (expected_outputs.size() == 0) begin
        $display("%0t: output %0d result %0d arrived with nothing expected",
                 $time, feat, $signed(res));
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      if (feat !== want.feature) begin
        $display("%0t: out_feature expected %0d actual %0d", $time, want.feature, feat);
        errors++;
      end
      if (res !== want.result) begin
        $display("%0t: out_result (feature %0d) expected %0d actual %0d", $time,
                 want.feature, $signed(want.result), $signed(res));
        errors++;
      end
      if (done !== want.row_done) begin
        $display("%0t: out_row_done (feature %0d) expected %0b actual %0b", $time,
                 want.feature, want.row_done, done);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the dense layer testbench: clock, reset, request and result drivers,
// register programming, directed and random stimulus, watchdog and verdict.
// Depends on dlbr_pkg, dlbr_tb_pkg and the dense_layer_bias_relu RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlbr_pkg::*;
  import dlbr_tb_pkg::*;

  localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN  = 16'sh8000;
  localparam logic signed [VAL_W-1:0] VAL_MAX  = 16'sh7fff;
  localparam int ITEM_GOAL   = 450;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 400;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DAT_W-1:0]    cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op;
  logic [FI_W-1:0]         in_feature_index;
  logic [OI_W-1:0]         in_output_index;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [OI_W-1:0]         out_feature;
  logic signed [VAL_W-1:0] out_result;
  logic                    out_row_done;

  dense_layer_tracker sb;
  bit                 calm;
  bit                 hold_request;
  bit                 offering;
  int                 items_sent;
  bit                 w_known [W_DEPTH];
  bit                 b_known [MAX_OUT_FEATURES];

  dense_layer_bias_relu i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_feature_index (in_feature_index),
    .in_output_index  (in_output_index),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_feature      (out_feature),
    .out_result       (out_result),
    .out_row_done     (out_row_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [VAL_W-1:0] rand_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: v = VAL_W'($urandom);
      5, 6, 7:       v = VAL_W'($urandom_range(1023)) - 16'sd512;
      default: begin
        case ($urandom_range(3))
          0:       v = VAL_MIN;
          1:       v = VAL_MAX;
          2:       v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send(input logic [OP_W-1:0] op, input logic [FI_W-1:0] fi,
                      input logic [OI_W-1:0] oi, input logic signed [VAL_W-1:0] val);
    while (!calm && $urandom_range(99) < 29) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    offering         = 1'b1;
    in_op            <= op;
    in_feature_index <= fi;
    in_output_index  <= oi;
    in_value         <= val;
    do @(posedge clk); while (!in_ready);
    if (op != OP_SPARE && !(op == OP_FEATURE && fi >= sb.used_in())) items_sent++;
    sb.note_request(op, fi, oi, val);
  endtask

  task automatic put_weight(input logic [FI_W-1:0] fi, input logic [OI_W-1:0] oi,
                            input logic signed [VAL_W-1:0] val);
    send(OP_WEIGHT, fi, oi, val);
    w_known[fi * MAX_OUT_FEATURES + oi] = 1'b1;
  endtask

  task automatic put_bias(input logic [OI_W-1:0] oi, input logic signed [VAL_W-1:0] val);
    send(OP_BIAS, FI_W'($urandom), oi, val);
    b_known[oi] = 1'b1;
  endtask

  // stores are undefined until written, so fill any gap this feature would read
  task automatic feature(input logic [FI_W-1:0] fi, input logic signed [VAL_W-1:0] val);
    if (fi < sb.used_in()) begin
      for (int k = 0; k < sb.used_out(); k++) begin
        if (!w_known[fi * MAX_OUT_FEATURES + k]) put_weight(fi, OI_W'(k), rand_value());
        if (!b_known[k]) put_bias(OI_W'(k), rand_value());
      end
    end
    send(OP_FEATURE, fi, OI_W'($urandom), val);
  endtask

  task automatic wait_results();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.expected_outputs.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic configure(input logic [CFG_DAT_W-1:0] in_c, input logic [CFG_DAT_W-1:0] out_c,
                           input logic relu_v, input bit spare);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DAT_W-1:0] data [4];
    int                   n;
    idx  = '{CFG_IN_COUNT, CFG_OUT_COUNT, CFG_RELU, CFG_SPARE};
    data = '{in_c, {2'($urandom), out_c[OUT_CNT_W-1:0]}, {6'($urandom), relu_v},
             CFG_DAT_W'($urandom)};
    n    = spare ? 4 : 3;
    for (int i = 0; i < n; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= data[i];
      @(posedge clk);
      sb.set_reg(idx[i], data[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_row();
    int nin;
    int stop_at;
    nin = sb.used_in();
    // now and then a row is abandoned part way
    stop_at = ($urandom_range(9) == 0) ? $urandom_range(nin - 1) : nin;
    for (int fi = 0; fi < stop_at; fi++) begin
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(4))
          0: put_weight(FI_W'($urandom), OI_W'($urandom), rand_value());
          1: put_bias(OI_W'($urandom), rand_value());
          2: send(OP_SPARE, FI_W'($urandom), OI_W'($urandom), VAL_W'($urandom));
          3: if (nin < MAX_IN_FEATURES) begin
            feature(FI_W'($urandom_range(MAX_IN_FEATURES - 1, nin)), rand_value());
          end
          default: feature(FI_W'($urandom_range(nin - 1)), rand_value());
        endcase
      end
      feature(FI_W'(fi), rand_value());
    end
  endtask

  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_output(out_feature, out_result, out_row_done);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 29);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] ic;
    logic [CFG_DAT_W-1:0] oc;
    logic                 relu_v;
    int                   n_rows;
    sb = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_IN_COUNT;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_op            <= OP_WEIGHT;
    in_feature_index <= '0;
    in_output_index  <= '0;
    in_value         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extreme values, saturation both ways, unused op, ignored and
    // out-of-order features, ReLU, zero-valued registers
    configure(7'd2, 7'd2, 1'b0, 1'b1);
    put_bias(4'd0, VAL_MAX);
    put_bias(4'd1, VAL_MIN);
    put_weight(6'd0, 4'd0, VAL_MIN);
    put_weight(6'd0, 4'd1, VAL_MAX);
    put_weight(6'd1, 4'd0, VAL_MIN);
    put_weight(6'd1, 4'd1, 16'sd1);
    put_weight(6'd63, 4'd15, '0);
    feature(6'd0, VAL_MIN);
    feature(6'd1, VAL_MIN);
    send(OP_SPARE, FI_W'($urandom), OI_W'($urandom), VAL_W'($urandom));
    feature(6'd5, VAL_MAX);
    feature(6'd1, 16'sd256);
    feature(6'd0, '0);
    feature(6'd1, -16'sd1);
    drain();
    configure(7'd2, 7'd2, 1'b1, 1'b0);
    feature(6'd0, 16'sd256);
    feature(6'd1, VAL_MIN);
    drain();
    configure(7'd0, 7'd0, 1'b0, 1'b0);
    feature(6'd0, VAL_MAX);
    feature(6'd1, '0);
    drain();

    // the calm pass and the held-off result pass always run
    for (int p = 0; items_sent < ITEM_GOAL || p < 6; p++) begin
      drain();
      calm = (p == 4);
      case (p)
        0: begin
          ic = 7'd127; oc = 7'd1; relu_v = 1'b1;
        end
        1: begin
          ic = 7'd1; oc = 7'd31; relu_v = 1'b0;
        end
        2: begin
          ic = 7'd0; oc = 7'd0; relu_v = 1'b1;
        end
        5: begin
          ic = 7'd2; oc = 7'd16; relu_v = 1'b0;
        end
        default: begin
          ic     = CFG_DAT_W'($urandom_range(8, 1));
          oc     = CFG_DAT_W'($urandom_range(16, 1));
          relu_v = $urandom_range(1);
        end
      endcase
      configure(ic, oc, relu_v, 1'b0);
      // result side holds off while requests keep coming
      if (p == 5) hold_request = 1'b1;
      n_rows = (p < 3) ? 2 : $urandom_range(5, 2);
      repeat (n_rows) begin
        run_row();
        if ($urandom_range(7) == 0) wait_results();
      end
    end

    calm = 1'b0;
    drain();
    if (sb.errors == 0 && sb.expected_outputs.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> files.f
rtl/dlbr_pkg.sv
rtl/dlbr_ram.sv
rtl/dlbr_ctrl.sv
rtl/dlbr_dp.sv
rtl/dense_layer_bias_relu.sv
tb/sv/dlbr_tb_pkg.sv
tb/sv/tb_top.sv
